FILE: rtl/core/mpdt_pkg.sv
package mpdt_pkg;

	localparam int CFG_INDEX_BITS = 8;
	localparam int REG_BITS       = 10;

	localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_X = 8'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_Y = 8'd1;

	localparam logic [REG_BITS-1:0] MAX_X_RST = 10'd628;
	localparam logic [REG_BITS-1:0] MAX_Y_RST = 10'd378;

	localparam int POS_X_RST = 320;
	localparam int POS_Y_RST = 200;

	localparam logic [7:0] HDR_MIN   = 8'hF8;
	localparam logic [7:0] KEY_LIMIT = 8'h80;
	localparam logic [7:0] HDR_NONE  = 8'hF8;
	localparam logic [7:0] HDR_LEFT  = 8'hF9;
	localparam logic [7:0] HDR_RIGHT = 8'hFA;
	localparam logic [7:0] HDR_BOTH  = 8'hFB;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_DX,
		PH_DY,
		PH_UNUSED
	} phase_t;

	typedef enum logic [1:0] {
		CLICK_NONE  = 2'd0,
		CLICK_LEFT  = 2'd1,
		CLICK_RIGHT = 2'd2,
		CLICK_BOTH  = 2'd3
	} click_t;

	typedef enum logic {
		KIND_BYTE   = 1'b0,
		KIND_UPDATE = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
	} item_t;

endpackage

FILE: rtl/core/mpdt_if.sv
interface mpdt_item_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;

	modport source (output valid, output kind, output data_byte, input ready);
	modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface mpdt_result_if #(
	parameter int COORD_BITS = 10
);
	logic                  valid;
	logic                  ready;
	logic                  key_valid;
	logic [6:0]            key_code;
	logic [COORD_BITS-1:0] cursor_x;
	logic [COORD_BITS-1:0] cursor_y;
	logic [1:0]            click;

	modport source (output valid, output key_valid, output key_code, output cursor_x,
		output cursor_y, output click, input ready);
	modport sink   (input valid, input key_valid, input key_code, input cursor_x,
		input cursor_y, input click, output ready);
endinterface

interface mpdt_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] index;
	logic [9:0] wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink   (input valid, input index, input wdata, output ready);
endinterface

FILE: rtl/core/mpdt_step.sv
module mpdt_step
	import mpdt_pkg::*;
#(
	parameter int COORD_BITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  item_t                 item,
	input  logic [REG_BITS-1:0]   max_x,
	input  logic [REG_BITS-1:0]   max_y,
	output logic                  key_valid,
	output logic [6:0]            key_code,
	output logic [COORD_BITS-1:0] cursor_x,
	output logic [COORD_BITS-1:0] cursor_y,
	output logic [1:0]            click
);

	localparam int SW = COORD_BITS + 2;
	localparam int LW = (COORD_BITS > REG_BITS) ? COORD_BITS : REG_BITS;
	localparam logic [COORD_BITS-1:0] POS_X_INIT = COORD_BITS'(POS_X_RST);
	localparam logic [COORD_BITS-1:0] POS_Y_INIT = COORD_BITS'(POS_Y_RST);

	phase_t                phase_q, phase_d;
	logic [7:0]            header_q, header_d;
	logic [7:0]            dx_q, dx_d;
	logic [7:0]            dy_q, dy_d;
	logic [COORD_BITS-1:0] pos_x_q, pos_x_d;
	logic [COORD_BITS-1:0] pos_y_q, pos_y_d;
	logic [1:0]            click_q, click_d;

	function automatic logic [COORD_BITS-1:0] clamp_axis(
		input logic [COORD_BITS-1:0] pos,
		input logic [7:0]            delta,
		input logic [REG_BITS-1:0]   maxv
	);
		logic [SW-1:0]         sum;
		logic [LW-1:0]         max_ext;
		logic [LW-1:0]         mask_ext;
		logic [COORD_BITS-1:0] lim;
		sum      = {2'b00, pos} + {{(SW-8){delta[7]}}, delta};
		max_ext  = LW'(maxv);
		mask_ext = LW'({COORD_BITS{1'b1}});
		lim      = (max_ext > mask_ext) ? {COORD_BITS{1'b1}} : COORD_BITS'(max_ext);
		if (sum[SW-1])
			return '0;
		else if (sum > {2'b00, lim})
			return lim;
		else
			return sum[COORD_BITS-1:0];
	endfunction

	always_comb begin
		phase_d   = phase_q;
		header_d  = header_q;
		dx_d      = dx_q;
		dy_d      = dy_q;
		pos_x_d   = pos_x_q;
		pos_y_d   = pos_y_q;
		click_d   = click_q;
		key_valid = 1'b0;
		key_code  = '0;
		if (item.kind == KIND_UPDATE) begin
			pos_x_d = clamp_axis(pos_x_q, dx_q, max_x);
			pos_y_d = clamp_axis(pos_y_q, dy_q, max_y);
			dx_d    = '0;
			dy_d    = '0;
			case (header_q)
				HDR_NONE:  click_d = CLICK_NONE;
				HDR_LEFT:  click_d = CLICK_LEFT;
				HDR_RIGHT: click_d = CLICK_RIGHT;
				HDR_BOTH:  click_d = CLICK_BOTH;
				default:   click_d = click_q;
			endcase
		end else begin
			case (phase_q)
				PH_HEADER: begin
					if (item.data_byte >= HDR_MIN) begin
						header_d = item.data_byte;
						phase_d  = PH_DX;
					end else if (item.data_byte < KEY_LIMIT) begin
						key_valid = 1'b1;
						key_code  = item.data_byte[6:0];
					end
				end
				PH_DX: begin
					dx_d    = item.data_byte;
					phase_d = PH_DY;
				end
				PH_DY: begin
					dy_d    = item.data_byte;
					phase_d = PH_HEADER;
				end
				default: phase_d = PH_HEADER;
			endcase
		end
		cursor_x = pos_x_d;
		cursor_y = pos_y_d;
		click    = click_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			header_q <= HDR_NONE;
			dx_q     <= '0;
			dy_q     <= '0;
			pos_x_q  <= POS_X_INIT;
			pos_y_q  <= POS_Y_INIT;
			click_q  <= CLICK_NONE;
		end else if (en) begin
			phase_q  <= phase_d;
			header_q <= header_d;
			dx_q     <= dx_d;
			dy_q     <= dy_d;
			pos_x_q  <= pos_x_d;
			pos_y_q  <= pos_y_d;
			click_q  <= click_d;
		end
	end

	a_update_clears_deltas: assert property (@(posedge clk) disable iff (!arst_n)
		en && item.kind == KIND_UPDATE |=> dx_q == '0 && dy_q == '0)
		else $error("deltas not cleared after update");

	a_header_starts_packet: assert property (@(posedge clk) disable iff (!arst_n)
		en && item.kind == KIND_BYTE && phase_q == PH_HEADER && item.data_byte >= HDR_MIN
		|=> phase_q == PH_DX && header_q == $past(item.data_byte))
		else $error("header did not start a packet");

	a_phase_reachable: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_UNUSED)
		else $error("packet phase reached unused code");

endmodule

FILE: rtl/core/mouse_packet_decoder_tracker.sv
// An accepted item waits in the input register, and its result is registered
// into the output register. One item per cycle while results are taken; while
// a result waits, a new item enters only an empty input register.
// Reset (arst_n low): cursor 320,200, click 0, no packet in progress,
// maxima 628 and 378, both stages empty.
module mouse_packet_decoder_tracker
	import mpdt_pkg::*;
#(
	parameter int COORD_BITS = 10
) (
	input  logic         clk,
	input  logic         arst_n,
	mpdt_item_if.sink    item_in,
	mpdt_result_if.source result_out,
	mpdt_cfg_if.sink     cfg
);

	logic                  valid_s1;
	item_t                 item_s1;
	logic                  valid_s2;
	logic                  key_valid_s2;
	logic [6:0]            key_code_s2;
	logic [COORD_BITS-1:0] cursor_x_s2;
	logic [COORD_BITS-1:0] cursor_y_s2;
	logic [1:0]            click_s2;

	logic [REG_BITS-1:0]   max_x_q;
	logic [REG_BITS-1:0]   max_y_q;

	logic                  advance;
	logic                  step_en;
	logic                  key_valid_c;
	logic [6:0]            key_code_c;
	logic [COORD_BITS-1:0] cursor_x_c;
	logic [COORD_BITS-1:0] cursor_y_c;
	logic [1:0]            click_c;

	assign advance       = !valid_s2 || result_out.ready;
	assign step_en       = valid_s1 && advance;
	assign item_in.ready = !valid_s1 || advance;
	assign cfg.ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_x_q <= MAX_X_RST;
			max_y_q <= MAX_Y_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MAX_X: max_x_q <= cfg.wdata;
				REG_MAX_Y: max_y_q <= cfg.wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_in.ready) begin
			valid_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_in.valid && item_in.ready) begin
			item_s1.kind      <= kind_t'(item_in.kind);
			item_s1.data_byte <= item_in.data_byte;
		end
	end

	mpdt_step #(
		.COORD_BITS(COORD_BITS)
	) u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (step_en),
		.item     (item_s1),
		.max_x    (max_x_q),
		.max_y    (max_y_q),
		.key_valid(key_valid_c),
		.key_code (key_code_c),
		.cursor_x (cursor_x_c),
		.cursor_y (cursor_y_c),
		.click    (click_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	// hold the result until the transaction completes
	always_ff @(posedge clk) begin
		if (step_en) begin
			key_valid_s2 <= key_valid_c;
			key_code_s2  <= key_code_c;
			cursor_x_s2  <= cursor_x_c;
			cursor_y_s2  <= cursor_y_c;
			click_s2     <= click_c;
		end
	end

	assign result_out.valid     = valid_s2;
	assign result_out.key_valid = key_valid_s2;
	assign result_out.key_code  = key_code_s2;
	assign result_out.cursor_x  = cursor_x_s2;
	assign result_out.cursor_y  = cursor_y_s2;
	assign result_out.click     = click_s2;

endmodule

FILE: tb/tb_mouse_packet_decoder_tracker.sv
`timescale 1ns / 1ps

module tb_mouse_packet_decoder_tracker;
	import mpdt_pkg::*;

	localparam int COORD       = 10;
	localparam int STALL_LIMIT = 1000;

	typedef struct packed {
		logic             key_valid;
		logic [6:0]       key_code;
		logic [COORD-1:0] cursor_x;
		logic [COORD-1:0] cursor_y;
		click_t           click;
	} cursor_report_t;

	logic clk;
	logic arst_n;

	mpdt_item_if                       item_if ();
	mpdt_result_if #(.COORD_BITS(COORD)) res_if ();
	mpdt_cfg_if                        cfg_if ();

	mouse_packet_decoder_tracker #(
		.COORD_BITS(COORD)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_if),
		.result_out (res_if),
		.cfg        (cfg_if)
	);

	// Tracker state as the block should hold it
	logic [COORD-1:0] lim_x     = MAX_X_RST;
	logic [COORD-1:0] lim_y     = MAX_Y_RST;
	phase_t           pkt_phase = PH_HEADER;
	logic [7:0]       hdr_held  = HDR_NONE;
	logic [7:0]       dx_held   = '0;
	logic [7:0]       dy_held   = '0;
	logic [COORD-1:0] cur_x     = COORD'(POS_X_RST);
	logic [COORD-1:0] cur_y     = COORD'(POS_Y_RST);
	click_t           click_now = CLICK_NONE;

	cursor_report_t expected_reports[$];
	int             mismatches  = 0;
	int             items_sent  = 0;
	int             idle_cycles = 0;
	int             stall_left  = 0;
	bit             quiet       = 1'b0;

	always #2 clk = ~clk;

	function automatic logic [COORD-1:0] clamp_move(logic [COORD-1:0] pos, logic [7:0] delta,
		logic [COORD-1:0] lim);
		int s;
		s = int'(pos) + int'($signed(delta));
		if (s < 0)
			return '0;
		if (s > int'(lim))
			return lim;
		return COORD'(s);
	endfunction

	task automatic predict_item(kind_t k, logic [7:0] b);
		cursor_report_t r;
		r = '0;
		if (k == KIND_UPDATE) begin
			cur_x   = clamp_move(cur_x, dx_held, lim_x);
			cur_y   = clamp_move(cur_y, dy_held, lim_y);
			dx_held = '0;
			dy_held = '0;
			case (hdr_held)
				HDR_NONE:  click_now = CLICK_NONE;
				HDR_LEFT:  click_now = CLICK_LEFT;
				HDR_RIGHT: click_now = CLICK_RIGHT;
				HDR_BOTH:  click_now = CLICK_BOTH;
				default:   ;
			endcase
		end else begin
			case (pkt_phase)
				PH_HEADER: begin
					if (b >= HDR_MIN) begin
						hdr_held  = b;
						pkt_phase = PH_DX;
					end else if (b < KEY_LIMIT) begin
						r.key_valid = 1'b1;
						r.key_code  = b[6:0];
					end
				end
				PH_DX: begin
					dx_held   = b;
					pkt_phase = PH_DY;
				end
				PH_DY: begin
					dy_held   = b;
					pkt_phase = PH_HEADER;
				end
				default: pkt_phase = PH_HEADER;
			endcase
		end
		r.cursor_x = cur_x;
		r.cursor_y = cur_y;
		r.click    = click_now;
		expected_reports.push_back(r);
	endtask

	// Called at a falling edge; leaves valid high so back-to-back transactions need no dip
	task automatic send_item(kind_t k, logic [7:0] b);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			item_if.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		item_if.valid     <= 1'b1;
		item_if.kind      <= k;
		item_if.data_byte <= b;
		@(posedge clk);
		while (!item_if.ready)
			@(posedge clk);
		predict_item(k, b);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_update();
		send_item(KIND_UPDATE, 8'($urandom_range(0, 255)));
	endtask

	task automatic drain_results();
		item_if.valid <= 1'b0;
		while (expected_reports.size() != 0)
			@(posedge clk);
		// hold off for the two-stage pipeline to settle
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [REG_BITS-1:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.wdata <= value;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		case (idx)
			REG_MAX_X: lim_x = value;
			REG_MAX_Y: lim_y = value;
			default:   ;
		endcase
		@(negedge clk);
	endtask

	task automatic apply_limits(logic [REG_BITS-1:0] x, logic [REG_BITS-1:0] y);
		drain_results();
		write_reg(REG_MAX_X, x);
		write_reg(REG_MAX_Y, y);
		cfg_if.valid <= 1'b0;
	endtask

	function automatic logic [7:0] pick_delta(int drift);
		if (drift == 0 || $urandom_range(0, 3) == 0)
			return 8'($urandom_range(0, 255));
		if (drift > 0)
			return 8'($urandom_range(64, 127));
		return 8'($urandom_range(128, 192));
	endfunction

	// Mostly complete packets; the rest keys, dropped bytes, lone and mid-packet updates
	task automatic run_random(int n_items, int drift);
		int         stop_at;
		int         pick;
		logic [7:0] hdr;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 9);
			if ($urandom_range(0, 4) == 0)
				hdr = 8'(HDR_BOTH + $urandom_range(1, 4));
			else
				hdr = 8'(HDR_NONE + $urandom_range(0, 3));
			case (pick)
				6: begin
					send_item(KIND_BYTE, hdr);
					send_item(KIND_BYTE, pick_delta(drift));
					send_update();
					send_item(KIND_BYTE, pick_delta(drift));
					send_update();
				end
				7: send_item(KIND_BYTE, 8'($urandom_range(0, KEY_LIMIT - 1)));
				8: send_item(KIND_BYTE, 8'($urandom_range(KEY_LIMIT, HDR_MIN - 1)));
				9: send_update();
				default: begin
					send_item(KIND_BYTE, hdr);
					send_item(KIND_BYTE, pick_delta(drift));
					send_item(KIND_BYTE, pick_delta(drift));
					send_update();
				end
			endcase
		end
	endtask

	task automatic test_key_codes();
		send_item(KIND_BYTE, 8'h00);
		send_item(KIND_BYTE, 8'h7F);
		send_item(KIND_BYTE, KEY_LIMIT);
		send_item(KIND_BYTE, HDR_MIN - 8'd1);
		send_item(KIND_BYTE, 8'h2A);
	endtask

	task automatic test_mouse_packets();
		send_item(KIND_BYTE, HDR_NONE);
		send_item(KIND_BYTE, 8'h7F);
		send_item(KIND_BYTE, 8'h80);
		send_item(KIND_UPDATE, 8'h00);
		send_item(KIND_BYTE, HDR_LEFT);
		send_item(KIND_BYTE, 8'h01);
		send_item(KIND_BYTE, 8'hFF);
		send_item(KIND_UPDATE, 8'hFF);
		send_item(KIND_BYTE, HDR_BOTH);
		send_item(KIND_BYTE, 8'h00);
		send_item(KIND_BYTE, 8'h00);
		send_item(KIND_UPDATE, 8'hAA);
		// header above the click range: click must stay as it was
		send_item(KIND_BYTE, 8'hFC);
		send_item(KIND_BYTE, 8'h05);
		send_item(KIND_BYTE, 8'h05);
		send_item(KIND_UPDATE, 8'h55);
		// update between delta X and delta Y
		send_item(KIND_BYTE, HDR_RIGHT);
		send_item(KIND_BYTE, 8'h10);
		send_item(KIND_UPDATE, 8'h33);
		send_item(KIND_BYTE, 8'hF0);
		send_item(KIND_UPDATE, 8'hCC);
	endtask

	task automatic test_limit_sweep();
		run_random(80, 0);
		apply_limits(10'd1023, 10'd1023);
		run_random(100, 1);
		// cursor sits far above the new maxima until the next update
		apply_limits(10'd0, 10'd0);
		run_random(60, 1);
		apply_limits(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
		run_random(80, -1);
		apply_limits(10'd1023, 10'd0);
		run_random(40, -1);
	endtask

	task automatic test_quiet_tail();
		apply_limits(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
		quiet = 1'b1;
		run_random(60, 0);
	endtask

	task automatic compare_field(string name, int want, int got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		cursor_report_t want;
		if (res_if.valid && res_if.ready) begin
			if (expected_reports.size() == 0) begin
				mismatches++;
				$display("%0t: result expected none actual x=%0d y=%0d", $time,
					res_if.cursor_x, res_if.cursor_y);
			end else begin
				want = expected_reports.pop_front();
				compare_field("key_valid", want.key_valid, res_if.key_valid);
				compare_field("key_code", want.key_code, res_if.key_code);
				compare_field("cursor_x", want.cursor_x, res_if.cursor_x);
				compare_field("cursor_y", want.cursor_y, res_if.cursor_y);
				compare_field("click", int'(want.click), res_if.click);
			end
		end
	end

	// Result-side stalls in bursts of random length
	always @(negedge clk) begin
		if (stall_left > 0) begin
			res_if.ready <= 1'b0;
			stall_left   <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			res_if.ready <= 1'b0;
			stall_left   <= $urandom_range(0, 4);
		end else begin
			res_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
			(cfg_if.valid && cfg_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("mouse_packet_decoder_tracker regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		clk               = 1'b0;
		arst_n            = 1'b0;
		item_if.valid     = 1'b0;
		item_if.kind      = KIND_BYTE;
		item_if.data_byte = '0;
		res_if.ready      = 1'b0;
		cfg_if.valid      = 1'b0;
		cfg_if.index      = REG_MAX_X;
		cfg_if.wdata      = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_key_codes();
		test_mouse_packets();
		test_limit_sweep();
		test_quiet_tail();

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("mouse_packet_decoder_tracker regression: pass");
		else
			$display("mouse_packet_decoder_tracker regression: fail");
		$finish;
	end

endmodule
